>>> design/vffs_pkg.sv
// Package for the video frame fit size block: payload, configuration and
// divider types, constants, the known source size table and small helpers.
// Depends on nothing; every other design file imports it.
package vffs_pkg;

	localparam int FIELD_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = 2 * FIELD_W;

	// Each divider: 48-bit dividend, 32-bit divisor, 17-bit quotient that
	// saturates at all ones. One quotient bit is resolved per stage.
	localparam int DIV_N_W    = 48;
	localparam int DIV_D_W    = 32;
	localparam int DIV_Q_W    = 17;
	localparam int DIV_STAGES = DIV_Q_W + 1;

	localparam int TABLE_ROWS         = 16;
	localparam int SIZE_TABLE_ENTRIES = 10;
	localparam int TBL_IDX_W          = 4;

	typedef enum logic [1:0] {
		FIT_STRETCH = 2'd0,
		FIT_NONE    = 2'd1,
		FIT_FILL    = 2'd2,
		FIT_KEEP    = 2'd3
	} vffs_fit_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_WIDTH  = 3'd0,
		REG_ACTIVE_HEIGHT = 3'd1,
		REG_FIT_MODE      = 3'd2,
		REG_FIRST_RATIO   = 3'd3,
		REG_SECOND_RATIO  = 3'd4,
		REG_LOWEST_RATIO  = 3'd5,
		REG_HIGHEST_RATIO = 3'd6
	} vffs_reg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] source_width;
		logic [FIELD_W-1:0] source_height;
		logic [FIELD_W-1:0] aspect_num;
		logic [FIELD_W-1:0] aspect_den;
	} vffs_src_t;

	typedef struct packed {
		logic [FIELD_W-1:0] out_width;
		logic [FIELD_W-1:0] out_height;
	} vffs_res_t;

	// Ratio packed as numerator in the upper half, denominator in the lower.
	typedef struct packed {
		logic [FIELD_W-1:0] n;
		logic [FIELD_W-1:0] d;
	} vffs_ratio_t;

	typedef struct packed {
		logic                 hit;
		logic [TBL_IDX_W-1:0] idx;
	} vffs_tbl_t;

	typedef struct packed {
		logic [FIELD_W-1:0] sw;
		logic [FIELD_W-1:0] sh;
		vffs_ratio_t        asp;
		vffs_tbl_t          tbl;
	} vffs_ctx_t;

	// Data that rides along the first division.
	typedef struct packed {
		logic [FIELD_W-1:0] oth;
		logic               s1w;
		logic               s2w;
		logic [PROD_W-1:0]  m2;
		logic [PROD_W-1:0]  q2;
		vffs_tbl_t          tbl;
	} vffs_side1_t;

	// Data that rides along the second division.
	typedef struct packed {
		logic [FIELD_W-1:0] oth;
		logic               s2w;
		vffs_tbl_t          tbl;
	} vffs_side2_t;

	localparam int DIV_SIDE_W = $bits(vffs_side1_t);
	localparam int SIDE2_W    = $bits(vffs_side2_t);

	typedef struct packed {
		logic                  valid;
		logic [DIV_N_W-1:0]    dividend;
		logic [DIV_D_W-1:0]    divisor;
		logic [DIV_SIDE_W-1:0] side;
	} vffs_div_req_t;

	typedef struct packed {
		logic                  valid;
		logic [DIV_Q_W-1:0]    quotient;
		logic [DIV_SIDE_W-1:0] side;
	} vffs_div_rsp_t;

	localparam logic [FIELD_W-1:0] ACTIVE_WIDTH_RST  = 16'd720;
	localparam logic [FIELD_W-1:0] ACTIVE_HEIGHT_RST = 16'd576;
	localparam vffs_ratio_t        FIRST_RATIO_RST   = '{n: 16'd4, d: 16'd3};

	// Known source sizes: width, height, correction numerator, denominator.
	localparam logic [FIELD_W-1:0] SIZE_TABLE [TABLE_ROWS][4] = '{
		'{16'd720, 16'd576, 16'd720,   16'd702},
		'{16'd704, 16'd576, 16'd704,   16'd702},
		'{16'd544, 16'd576, 16'd1088,  16'd1053},
		'{16'd480, 16'd576, 16'd480,   16'd468},
		'{16'd384, 16'd288, 16'd768,   16'd767},
		'{16'd352, 16'd576, 16'd352,   16'd351},
		'{16'd352, 16'd288, 16'd352,   16'd351},
		'{16'd176, 16'd144, 16'd352,   16'd351},
		'{16'd720, 16'd480, 16'd1600,  16'd1587},
		'{16'd704, 16'd480, 16'd14080, 16'd14283},
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0}
	};

	// First matching row wins, so the scan runs from the bottom up.
	function automatic vffs_tbl_t tbl_find(input logic [FIELD_W-1:0] sw,
			input logic [FIELD_W-1:0] sh);
		vffs_tbl_t r;
		r = '0;
		for (int i = TABLE_ROWS - 1; i >= 0; i--) begin
			if (i < SIZE_TABLE_ENTRIES && SIZE_TABLE[i][0] != '0 &&
					sw == SIZE_TABLE[i][0] && sh == SIZE_TABLE[i][1]) begin
				r.hit = 1'b1;
				r.idx = TBL_IDX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [PROD_W-1:0] absdiff(input logic [PROD_W-1:0] a,
			input logic [PROD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [FIELD_W-1:0] sat16(input logic [DIV_Q_W-1:0] v);
		return v[DIV_Q_W-1] ? '1 : v[FIELD_W-1:0];
	endfunction

endpackage

>>> design/vffs_div.sv
// Pipelined restoring divider with a saturating 17-bit quotient and a
// sideband that travels with each item. Depends on vffs_pkg.
module vffs_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vffs_pkg::vffs_div_req_t req,
	output vffs_pkg::vffs_div_rsp_t rsp
);
	import vffs_pkg::*;

	typedef struct packed {
		logic [DIV_D_W-1:0]    rem;
		logic [DIV_D_W-1:0]    dvs;
		logic [DIV_Q_W-1:0]    low;
		logic [DIV_Q_W-1:0]    quo;
		logic                  sat;
		logic                  zero;
		logic [DIV_SIDE_W-1:0] side;
	} div_stg_t;

	logic [DIV_STAGES-1:0] vld_s;
	div_stg_t              stg_s [DIV_STAGES];
	div_stg_t              head;

	// One quotient bit: shift in the next dividend bit, subtract if it fits.
	function automatic div_stg_t div_step(input div_stg_t p);
		div_stg_t           n;
		logic [DIV_D_W:0]   t;
		logic               ge;
		n = p;
		t = {p.rem, p.low[DIV_Q_W-1]};
		ge = t >= {1'b0, p.dvs};
		n.rem = ge ? DIV_D_W'(t - {1'b0, p.dvs}) : t[DIV_D_W-1:0];
		n.low = {p.low[DIV_Q_W-2:0], 1'b0};
		n.quo = {p.quo[DIV_Q_W-2:0], ge};
		return n;
	endfunction

	// The upper dividend bits start as the partial remainder. If they already
	// reach the divisor, the quotient does not fit and saturates.
	always_comb begin
		head.rem  = DIV_D_W'(req.dividend[DIV_N_W-1:DIV_Q_W]);
		head.dvs  = req.divisor;
		head.low  = req.dividend[DIV_Q_W-1:0];
		head.quo  = '0;
		head.sat  = DIV_D_W'(req.dividend[DIV_N_W-1:DIV_Q_W]) >= req.divisor;
		head.zero = req.divisor == '0;
		head.side = req.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DIV_STAGES-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= head;
		for (int k = 1; k < DIV_STAGES; k++) begin
			stg_s[k] <= div_step(stg_s[k-1]);
		end
	end

	always_comb begin
		rsp.valid = vld_s[DIV_STAGES-1];
		rsp.side  = stg_s[DIV_STAGES-1].side;
		if (stg_s[DIV_STAGES-1].zero) begin
			rsp.quotient = '0;
		end else if (stg_s[DIV_STAGES-1].sat) begin
			rsp.quotient = '1;
		end else begin
			rsp.quotient = stg_s[DIV_STAGES-1].quo;
		end
	end

endmodule

>>> design/video_frame_fit_size.sv
// Top level of the video frame fit size block: configuration registers,
// ratio selection pipeline and three chained dividers. Depends on vffs_pkg
// and vffs_div.
//
// Usage. Software writes the seven configuration registers through cfg_we,
// cfg_idx and cfg_wdata while no item is in flight; a write takes effect at
// the clock edge where cfg_we is high. An item (source size and source
// aspect ratio) is accepted at every rising edge where start is high and
// busy is low. The block is a free-running pipeline, so busy is always low
// and a new item may be given in every cycle.
// Each item yields exactly one result: done is high for one cycle while
// result holds the fitted width and height. The item passes 72 register
// stages, the first of them loaded at the accepting edge: 15 stages choose
// the target ratio and form the first scale factor, then each of three
// dividers (17 quotient bits, one per stage, plus a setup stage) is followed
// by one stage that forms the next multiplication or the output register.
// Throughput is one item per cycle.
// The receiver cannot stall, so nothing is held back on the output side.
// Reset clears all valid bits, so no result is reported for items that were
// in flight, and returns the registers to their documented defaults.
module video_frame_fit_size (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  vffs_pkg::vffs_src_t                  source,
	output logic                                 done,
	output vffs_pkg::vffs_res_t                  result,
	input  logic                                 cfg_we,
	input  logic [vffs_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [vffs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import vffs_pkg::*;

	// Configuration registers.
	logic [FIELD_W-1:0] aw_q;
	logic [FIELD_W-1:0] ah_q;
	vffs_fit_t          mode_q;
	vffs_ratio_t        d0_q;
	vffs_ratio_t        d1_q;
	vffs_ratio_t        lo_q;
	vffs_ratio_t        hi_q;

	// Ratio pipeline.
	logic [15:1]        vld_s;
	vffs_ctx_t          ctx_in;
	vffs_ctx_t          ctx_s [1:13];
	logic [PROD_W-1:0]  pa0_s1, p0a_s1, pa1_s1, p1a_s1;
	logic [PROD_W-1:0]  dif0_s2, dif1_s2;
	logic [DIV_N_W-1:0] dx_s3, dy_s3;
	vffs_ratio_t        c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10, c_s11, c_s12;
	logic [PROD_W-1:0]  lo1_s5, lo2_s5, hi1_s7, hi2_s7;
	logic [PROD_W-1:0]  pc0_s9, p0c_s9, pc1_s9, p1c_s9;
	logic [PROD_W-1:0]  dif0_s10, dif1_s10;
	logic [DIV_N_W-1:0] dx_s11, dy_s11;
	vffs_ratio_t        b_s12;
	logic [PROD_W-1:0]  pc_s13, pb_s13, qc_s13, qa_s13;

	// Scale factor selection.
	logic               gt1, lt1, gt2, lt2;
	logic [FIELD_W-1:0] v1;
	logic [PROD_W-1:0]  m1, q1;
	vffs_side1_t        side1;
	logic [FIELD_W-1:0] v1_s14;
	logic [PROD_W-1:0]  m1_s14, q1_s14;
	vffs_side1_t        side1_s14;
	logic [DIV_N_W-1:0] dvd1_s15;
	logic [DIV_D_W-1:0] dvs1_s15;
	vffs_side1_t        side1_s15;

	// Divider chain.
	vffs_div_req_t      req1, req2, req3;
	vffs_div_rsp_t      rsp1, rsp2, rsp3;
	vffs_side1_t        r1;
	vffs_side2_t        r2;
	logic [FIELD_W-1:0] q1v, w1, h1, v2;
	vffs_side2_t        side2;
	logic               vld_s16, vld_s17;
	logic [DIV_N_W-1:0] dvd2_s16, dvd3_s17;
	logic [DIV_D_W-1:0] dvs2_s16, dvs3_s17;
	vffs_side2_t        side2_s16;
	logic [DIV_Q_W-1:0] w2, h2, h2_s17;
	logic [FIELD_W-1:0] tm, tq;

	logic               done_q;
	vffs_res_t          res_q;

	assign busy = 1'b0;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q   <= ACTIVE_WIDTH_RST;
			ah_q   <= ACTIVE_HEIGHT_RST;
			mode_q <= FIT_KEEP;
			d0_q   <= FIRST_RATIO_RST;
			d1_q   <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else if (cfg_we) begin
			unique case (vffs_reg_t'(cfg_idx))
				REG_ACTIVE_WIDTH:  aw_q <= cfg_wdata[FIELD_W-1:0];
				REG_ACTIVE_HEIGHT: ah_q <= cfg_wdata[FIELD_W-1:0];
				REG_FIT_MODE:      mode_q <= vffs_fit_t'(cfg_wdata[1:0]);
				REG_FIRST_RATIO:   d0_q <= vffs_ratio_t'(cfg_wdata);
				REG_SECOND_RATIO:  d1_q <= vffs_ratio_t'(cfg_wdata);
				REG_LOWEST_RATIO:  lo_q <= vffs_ratio_t'(cfg_wdata);
				REG_HIGHEST_RATIO: hi_q <= vffs_ratio_t'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// An unset source aspect falls back to square pixels; the size table is
	// searched here so that only a row index travels down the pipeline.
	always_comb begin
		ctx_in.sw = source.source_width;
		ctx_in.sh = source.source_height;
		if (source.aspect_num == '0 || source.aspect_den == '0) begin
			ctx_in.asp.n = source.source_width;
			ctx_in.asp.d = source.source_height;
		end else begin
			ctx_in.asp.n = source.aspect_num;
			ctx_in.asp.d = source.aspect_den;
		end
		ctx_in.tbl = tbl_find(source.source_width, source.source_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[14:1], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		ctx_s[1] <= ctx_in;
		for (int k = 2; k <= 13; k++) begin
			ctx_s[k] <= ctx_s[k-1];
		end

		// Fill mode target: the display ratio nearer to the source aspect,
		// compared by cross products; a tie keeps the first display ratio.
		pa0_s1 <= PROD_W'(ctx_in.asp.n) * PROD_W'(d0_q.d);
		p0a_s1 <= PROD_W'(d0_q.n) * PROD_W'(ctx_in.asp.d);
		pa1_s1 <= PROD_W'(ctx_in.asp.n) * PROD_W'(d1_q.d);
		p1a_s1 <= PROD_W'(d1_q.n) * PROD_W'(ctx_in.asp.d);

		dif0_s2 <= absdiff(pa0_s1, p0a_s1);
		dif1_s2 <= absdiff(pa1_s1, p1a_s1);

		dx_s3 <= DIV_N_W'(dif0_s2) * DIV_N_W'(d1_q.d);
		dy_s3 <= DIV_N_W'(dif1_s2) * DIV_N_W'(d0_q.d);

		if (mode_q == FIT_FILL) begin
			c_s4 <= (d1_q.d != '0 && dy_s3 < dx_s3) ? d1_q : d0_q;
		end else begin
			c_s4 <= ctx_s[3].asp;
		end

		// Clamp to the lowest and then the highest ratio, when present.
		c_s5   <= c_s4;
		lo1_s5 <= PROD_W'(c_s4.n) * PROD_W'(lo_q.d);
		lo2_s5 <= PROD_W'(lo_q.n) * PROD_W'(c_s4.d);
		c_s6   <= (lo_q.d != '0 && lo1_s5 < lo2_s5) ? lo_q : c_s5;

		c_s7   <= c_s6;
		hi1_s7 <= PROD_W'(c_s6.n) * PROD_W'(hi_q.d);
		hi2_s7 <= PROD_W'(hi_q.n) * PROD_W'(c_s6.d);
		c_s8   <= (hi_q.d != '0 && hi1_s7 > hi2_s7) ? hi_q : c_s7;

		// Display ratio nearer to the clamped ratio.
		c_s9   <= c_s8;
		pc0_s9 <= PROD_W'(c_s8.n) * PROD_W'(d0_q.d);
		p0c_s9 <= PROD_W'(d0_q.n) * PROD_W'(c_s8.d);
		pc1_s9 <= PROD_W'(c_s8.n) * PROD_W'(d1_q.d);
		p1c_s9 <= PROD_W'(d1_q.n) * PROD_W'(c_s8.d);

		c_s10    <= c_s9;
		dif0_s10 <= absdiff(pc0_s9, p0c_s9);
		dif1_s10 <= absdiff(pc1_s9, p1c_s9);

		c_s11  <= c_s10;
		dx_s11 <= DIV_N_W'(dif0_s10) * DIV_N_W'(d1_q.d);
		dy_s11 <= DIV_N_W'(dif1_s10) * DIV_N_W'(d0_q.d);

		c_s12 <= c_s11;
		b_s12 <= (d1_q.d != '0 && dy_s11 < dx_s11) ? d1_q : d0_q;

		// Cross products that both decide and scale the two fit steps.
		pc_s13 <= PROD_W'(c_s12.n) * PROD_W'(b_s12.d);
		pb_s13 <= PROD_W'(b_s12.n) * PROD_W'(c_s12.d);
		qc_s13 <= PROD_W'(c_s12.n) * PROD_W'(ctx_s[12].asp.d);
		qa_s13 <= PROD_W'(ctx_s[12].asp.n) * PROD_W'(c_s12.d);
	end

	// Each fit step scales either the height or the width by m/q; a step that
	// does nothing uses m = q = 1 so that every item takes the same path.
	always_comb begin
		gt1 = pc_s13 > pb_s13;
		lt1 = pc_s13 < pb_s13;
		gt2 = qc_s13 > qa_s13;
		lt2 = qc_s13 < qa_s13;
		v1 = ah_q;
		m1 = PROD_W'(1);
		q1 = PROD_W'(1);
		side1.oth = aw_q;
		side1.s1w = 1'b0;
		side1.s2w = 1'b0;
		side1.m2  = PROD_W'(1);
		side1.q2  = PROD_W'(1);
		side1.tbl = ctx_s[13].tbl;
		unique case (mode_q)
			FIT_NONE: begin
				v1 = ctx_s[13].sh;
				side1.oth = ctx_s[13].sw;
				side1.tbl = '0;
			end
			FIT_STRETCH: begin
			end
			FIT_FILL, FIT_KEEP: begin
				// Letterbox or pillarbox against the display ratio.
				if (gt1) begin
					m1 = pb_s13;
					q1 = pc_s13;
				end else if (lt1) begin
					v1 = aw_q;
					side1.oth = ah_q;
					side1.s1w = 1'b1;
					m1 = pc_s13;
					q1 = pb_s13;
				end
				// Correction from the chosen ratio back to the source aspect.
				if (gt2) begin
					side1.m2 = qc_s13;
					side1.q2 = qa_s13;
				end else if (lt2) begin
					side1.s2w = 1'b1;
					side1.m2 = qa_s13;
					side1.q2 = qc_s13;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		v1_s14    <= v1;
		m1_s14    <= m1;
		q1_s14    <= q1;
		side1_s14 <= side1;
		dvd1_s15  <= DIV_N_W'(v1_s14) * DIV_N_W'(m1_s14);
		dvs1_s15  <= q1_s14;
		side1_s15 <= side1_s14;
	end

	assign req1 = '{valid: vld_s[15], dividend: dvd1_s15, divisor: dvs1_s15,
		side: side1_s15};

	vffs_div u_div1 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req1),
		.rsp    (rsp1)
	);

	// The first step never enlarges its operand, so its quotient fits 16 bits.
	always_comb begin
		r1  = vffs_side1_t'(rsp1.side);
		q1v = rsp1.quotient[FIELD_W-1:0];
		w1  = r1.s1w ? q1v : r1.oth;
		h1  = r1.s1w ? r1.oth : q1v;
		v2  = r1.s2w ? w1 : h1;
		side2.oth = r1.s2w ? h1 : w1;
		side2.s2w = r1.s2w;
		side2.tbl = r1.tbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s16 <= rsp1.valid;
			vld_s17 <= rsp2.valid;
			done_q  <= rsp3.valid;
		end
	end

	always_ff @(posedge clk) begin
		dvd2_s16  <= DIV_N_W'(v2) * DIV_N_W'(r1.m2);
		dvs2_s16  <= r1.q2;
		side2_s16 <= side2;
	end

	assign req2 = '{valid: vld_s16, dividend: dvd2_s16, divisor: dvs2_s16,
		side: DIV_SIDE_W'(side2_s16)};

	vffs_div u_div2 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req2),
		.rsp    (rsp2)
	);

	// A width saturated at 17 bits still saturates after the table factor,
	// whose smallest value is close to one.
	always_comb begin
		r2 = vffs_side2_t'(rsp2.side[SIDE2_W-1:0]);
		w2 = r2.s2w ? rsp2.quotient : {1'b0, r2.oth};
		h2 = r2.s2w ? {1'b0, r2.oth} : rsp2.quotient;
		tm = r2.tbl.hit ? SIZE_TABLE[r2.tbl.idx][2] : FIELD_W'(1);
		tq = r2.tbl.hit ? SIZE_TABLE[r2.tbl.idx][3] : FIELD_W'(1);
	end

	always_ff @(posedge clk) begin
		dvd3_s17 <= DIV_N_W'(w2) * DIV_N_W'(tm);
		dvs3_s17 <= DIV_D_W'(tq);
		h2_s17   <= h2;
	end

	assign req3 = '{valid: vld_s17, dividend: dvd3_s17, divisor: dvs3_s17,
		side: DIV_SIDE_W'(h2_s17)};

	vffs_div u_div3 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req3),
		.rsp    (rsp3)
	);

	always_ff @(posedge clk) begin
		res_q.out_width  <= sat16(rsp3.quotient);
		res_q.out_height <= sat16(rsp3.side[DIV_Q_W-1:0]);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> test/tb_video_frame_fit_size.sv
// Self-checking testbench for video_frame_fit_size: a clocked driver, a clocked
// monitor and a behavioral predictor of the fitted width and height.
// Depends on vffs_pkg and the design files of the block.
module tb_video_frame_fit_size;
	import vffs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 100;

	localparam logic [15:0] KNOWN_W [10] = '{720, 704, 544, 480, 384, 352, 352, 176, 720, 704};
	localparam logic [15:0] KNOWN_H [10] = '{576, 576, 576, 576, 288, 576, 288, 144, 480, 480};
	localparam logic [15:0] KNOWN_N [10] = '{720, 704, 1088, 480, 768, 352, 352, 352, 1600,
		14080};
	localparam logic [15:0] KNOWN_D [10] = '{702, 702, 1053, 468, 767, 351, 351, 351, 1587,
		14283};

	typedef enum {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

	typedef struct {
		act_kind_t             kind;
		vffs_src_t             src;
		vffs_reg_t             idx;
		logic [CFG_DATA_W-1:0] data;
	} action_t;

	// Ratios are widened to 64 bits so that every cross product stays exact.
	typedef struct {
		logic [63:0] n;
		logic [63:0] d;
	} wide_ratio_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	vffs_src_t             source = '0;
	logic                  done;
	vffs_res_t             result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	action_t   pending_q[$];
	vffs_res_t fitted_q[$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        burst_left = 0;
	int        gap_left = 0;

	// Shadow copy of the configuration registers, at their reset values.
	logic [15:0] sh_width = 16'd720;
	logic [15:0] sh_height = 16'd576;
	vffs_fit_t   sh_mode = FIT_KEEP;
	logic [31:0] sh_first = 32'h0004_0003;
	logic [31:0] sh_second = '0;
	logic [31:0] sh_lowest = '0;
	logic [31:0] sh_highest = '0;

	video_frame_fit_size u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.source    (source),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic wide_ratio_t widen(input logic [31:0] v);
		wide_ratio_t r;
		r.n = {48'd0, v[31:16]};
		r.d = {48'd0, v[15:0]};
		return r;
	endfunction

	// Exact comparison of a against b by cross multiplication.
	function automatic int ratio_order(input wide_ratio_t a, input wide_ratio_t b);
		logic [63:0] l;
		logic [63:0] r;
		l = a.n * b.d;
		r = b.n * a.d;
		if (l < r) return -1;
		if (l > r) return 1;
		return 0;
	endfunction

	function automatic logic [63:0] wide_gap(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// The nearer of x and y to target; a tie keeps x.
	function automatic wide_ratio_t nearer_ratio(input wide_ratio_t target,
			input wide_ratio_t x, input wide_ratio_t y);
		logic [63:0] dx;
		logic [63:0] dy;
		dx = wide_gap(target.n * x.d, x.n * target.d) * y.d;
		dy = wide_gap(target.n * y.d, y.n * target.d) * x.d;
		return (dy < dx) ? y : x;
	endfunction

	function automatic logic [63:0] scale(input logic [63:0] v, input logic [63:0] m,
			input logic [63:0] q);
		if (q == 0) return 64'd0;
		return v * m / q;
	endfunction

	function automatic vffs_res_t fitted_size(input vffs_src_t s);
		vffs_res_t   r;
		wide_ratio_t asp;
		wide_ratio_t c;
		wide_ratio_t b;
		wide_ratio_t d0;
		wide_ratio_t d1;
		wide_ratio_t lo;
		wide_ratio_t hi;
		logic [63:0] w;
		logic [63:0] h;
		bit          found;
		w = {48'd0, sh_width};
		h = {48'd0, sh_height};
		if (sh_mode == FIT_NONE) begin
			r.out_width = s.source_width;
			r.out_height = s.source_height;
			return r;
		end
		if (sh_mode != FIT_STRETCH) begin
			asp.n = {48'd0, s.aspect_num};
			asp.d = {48'd0, s.aspect_den};
			// An unset aspect falls back to square pixels.
			if (asp.n == 0 || asp.d == 0) begin
				asp.n = {48'd0, s.source_width};
				asp.d = {48'd0, s.source_height};
			end
			d0 = widen(sh_first);
			d1 = widen(sh_second);
			lo = widen(sh_lowest);
			hi = widen(sh_highest);
			if (sh_mode == FIT_FILL) begin
				c = d0;
				if (d1.d != 0) c = nearer_ratio(asp, d0, d1);
			end else begin
				c = asp;
			end
			if (lo.d != 0 && ratio_order(c, lo) < 0) c = lo;
			if (hi.d != 0 && ratio_order(c, hi) > 0) c = hi;
			b = d0;
			if (d1.d != 0) b = nearer_ratio(c, d0, d1);
			if (ratio_order(c, b) > 0)
				h = scale(h, b.n * c.d, b.d * c.n);
			else if (ratio_order(c, b) < 0)
				w = scale(w, c.n * b.d, c.d * b.n);
			if (ratio_order(c, asp) > 0)
				h = scale(h, c.n * asp.d, c.d * asp.n);
			else if (ratio_order(c, asp) < 0)
				w = scale(w, asp.n * c.d, asp.d * c.n);
		end
		// Known source sizes get a width correction; the first match applies.
		found = 1'b0;
		for (int i = 0; i < 10; i++) begin
			if (!found && s.source_width == KNOWN_W[i] && s.source_height == KNOWN_H[i]) begin
				w = scale(w, {48'd0, KNOWN_N[i]}, {48'd0, KNOWN_D[i]});
				found = 1'b1;
			end
		end
		r.out_width = (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
		r.out_height = (h > 64'hFFFF) ? 16'hFFFF : h[15:0];
		return r;
	endfunction

	function automatic void shadow_write(input vffs_reg_t idx, input logic [31:0] v);
		case (idx)
			REG_ACTIVE_WIDTH:  sh_width = v[15:0];
			REG_ACTIVE_HEIGHT: sh_height = v[15:0];
			REG_FIT_MODE:      sh_mode = vffs_fit_t'(v[1:0]);
			REG_FIRST_RATIO:   sh_first = v;
			REG_SECOND_RATIO:  sh_second = v;
			REG_LOWEST_RATIO:  sh_lowest = v;
			REG_HIGHEST_RATIO: sh_highest = v;
			default: ;
		endcase
	endfunction

	task automatic queue_item(input logic [15:0] sw, input logic [15:0] sh,
			input logic [15:0] an, input logic [15:0] ad);
		action_t a;
		a.kind = ACT_ITEM;
		a.src = '{source_width: sw, source_height: sh, aspect_num: an, aspect_den: ad};
		a.idx = REG_ACTIVE_WIDTH;
		a.data = '0;
		pending_q.push_back(a);
	endtask

	// A full set of register writes, preceded by a wait for the pipeline to empty.
	task automatic queue_settings(input logic [15:0] aw, input logic [15:0] ah,
			input vffs_fit_t mode, input logic [31:0] r0, input logic [31:0] r1,
			input logic [31:0] rlo, input logic [31:0] rhi);
		action_t a;
		logic [31:0] vals [7];
		vals = '{{16'd0, aw}, {16'd0, ah}, {30'd0, mode}, r0, r1, rlo, rhi};
		a.kind = ACT_DRAIN;
		a.src = '0;
		a.idx = REG_ACTIVE_WIDTH;
		a.data = '0;
		pending_q.push_back(a);
		for (int i = 0; i < 7; i++) begin
			a.kind = ACT_CFG;
			a.idx = vffs_reg_t'(i);
			a.data = vals[i];
			pending_q.push_back(a);
		end
	endtask

	// Mostly small ratios, sometimes an absent one, sometimes anything at all.
	function automatic logic [31:0] any_ratio();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) return {16'($urandom_range(0, 20)), 16'd0};
		if (pick < 4) return $urandom;
		return {16'($urandom_range(1, 20)), 16'($urandom_range(1, 20))};
	endfunction

	task automatic queue_random_item();
		int          pick;
		int          row;
		logic [15:0] sw;
		logic [15:0] sh;
		logic [15:0] an;
		logic [15:0] ad;
		pick = $urandom_range(0, 9);
		row = $urandom_range(0, 9);
		if (pick < 3) begin
			sw = KNOWN_W[row];
			sh = KNOWN_H[row];
		end else if (pick < 6) begin
			sw = 16'($urandom_range(0, 2000));
			sh = 16'($urandom_range(0, 2000));
		end else begin
			sw = 16'($urandom);
			sh = 16'($urandom);
		end
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			an = (pick == 0) ? 16'd0 : 16'($urandom);
			ad = (pick == 1) ? 16'd0 : 16'($urandom);
		end else if (pick < 7) begin
			an = 16'($urandom_range(1, 21));
			ad = 16'($urandom_range(1, 21));
		end else begin
			an = 16'($urandom);
			ad = 16'($urandom);
		end
		queue_item(sw, sh, an, ad);
	endtask

	// Driver: presents items in bursts, writes registers and waits at drain points.
	always @(posedge clk) begin : drive
		logic      next_start;
		logic      next_we;
		action_t   head;
		next_start = 1'b0;
		next_we = 1'b0;
		if (arst_n) begin
			// The expectation is formed with the settings in force when the item is taken.
			if (start && !busy) fitted_q.push_back(fitted_size(source));
			if (start && busy) begin
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_q.size() > 0) begin
				head = pending_q[0];
				case (head.kind)
					ACT_ITEM: begin
						next_start = 1'b1;
						source <= head.src;
						void'(pending_q.pop_front());
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 60);
							gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
						end
					end
					ACT_CFG: begin
						next_we = 1'b1;
						cfg_idx <= head.idx;
						cfg_wdata <= head.data;
						shadow_write(head.idx, head.data);
						void'(pending_q.pop_front());
					end
					default: begin
						// Every item yields a result, so an empty store means an idle block.
						if (!start && fitted_q.size() == 0) void'(pending_q.pop_front());
					end
				endcase
			end
		end
		start <= next_start;
		cfg_we <= next_we;
	end

	// Monitor: each strobed result is checked against the oldest expectation.
	always @(posedge clk) begin : watch
		vffs_res_t want;
		if (arst_n && done) begin
			if (fitted_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				want = fitted_q.pop_front();
				if (result.out_width !== want.out_width) begin
					$display("%0t: out_width expected %0d actual %0d", $time,
						want.out_width, result.out_width);
					errors++;
				end
				if (result.out_height !== want.out_height) begin
					$display("%0t: out_height expected %0d actual %0d", $time,
						want.out_height, result.out_height);
					errors++;
				end
			end
		end
	end

	// Watchdog: the run is stuck if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("video_frame_fit_size: mismatch");
				$finish;
			end
		end
	end

	initial begin
		// Directed part, first under the reset settings (fit keeping aspect, 4:3).
		queue_item(16'd720, 16'd576, 16'd16, 16'd9);
		queue_item(16'd0, 16'd0, 16'd0, 16'd0);
		queue_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_item(16'd704, 16'd480, 16'd0, 16'd3);
		queue_item(16'd640, 16'd0, 16'd4, 16'd0);
		queue_item(16'd352, 16'd288, 16'd4, 16'd3);
		queue_item(16'd176, 16'd144, 16'd1, 16'hFFFF);
		// Fill with two display ratios; 14:9 lies exactly between 4:3 and 16:9 on a tie.
		queue_settings(16'd720, 16'd576, FIT_FILL, 32'h0004_0003, 32'h0010_0009, 32'd0, 32'd0);
		queue_item(16'd720, 16'd576, 16'd14, 16'd9);
		queue_item(16'd720, 16'd576, 16'd16, 16'd9);
		queue_item(16'd1920, 16'd1080, 16'd0, 16'd0);
		queue_item(16'd544, 16'd576, 16'd5, 16'd4);
		// Limits clamp the ratio; also extremes of the frame size.
		queue_settings(16'hFFFF, 16'hFFFF, FIT_KEEP, 32'h0004_0003, 32'h0010_0009,
			32'h0005_0004, 32'h0002_0001);
		queue_item(16'd720, 16'd576, 16'd1, 16'd1);
		queue_item(16'd720, 16'd576, 16'd3, 16'd1);
		queue_item(16'd480, 16'd576, 16'd0, 16'd0);
		queue_settings(16'd0, 16'd0, FIT_STRETCH, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_item(16'd720, 16'd480, 16'd4, 16'd3);
		queue_item(16'd100, 16'd100, 16'd4, 16'd3);
		queue_settings(16'd800, 16'd600, FIT_NONE, '1, '1, '1, '1);
		queue_item(16'd720, 16'd576, 16'd4, 16'd3);
		queue_item(16'hFFFF, 16'd0, 16'd0, 16'd0);
		queue_settings(16'd720, 16'd576, FIT_KEEP, '1, '1, '1, '1);
		queue_item(16'd384, 16'd288, 16'd4, 16'd3);
		queue_item(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		// Random part: ten phases of random settings with random items.
		for (int p = 0; p < 10; p++) begin
			queue_settings((p % 3 == 0) ? 16'($urandom) : 16'($urandom_range(100, 2000)),
				(p % 3 == 0) ? 16'($urandom) : 16'($urandom_range(100, 2000)),
				vffs_fit_t'((p < 8) ? ((p % 2) ? FIT_FILL : FIT_KEEP) : $urandom_range(0, 3)),
				any_ratio(), any_ratio(), any_ratio(), any_ratio());
			for (int i = 0; i < 100; i++) queue_random_item();
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0) @(posedge clk);
		while (fitted_q.size() != 0 || start) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("video_frame_fit_size: match");
		else
			$display("video_frame_fit_size: mismatch");
		$finish;
	end

endmodule
